>>> rtl/swvs_pkg.sv
// shared types, constants and helper functions of the square-wave sweep sequencer
`default_nettype none

package swvs_pkg;

    localparam int LVL_W      = 17;
    localparam int CALC_W     = 20;
    localparam int TIME_W     = 32;
    localparam int TOTAL_W    = 20;
    localparam int DIV_CNT_W  = 5;
    localparam int REM_W      = 15;
    localparam int PROD_W     = 40;

    localparam logic [2:0] MAX_VERTICES = 3'd4;

    localparam logic [2:0] REG_START_LEVEL  = 3'd0;
    localparam logic [2:0] REG_END_LEVEL    = 3'd1;
    localparam logic [2:0] REG_VERTEX_TABLE = 3'd2;
    localparam logic [2:0] REG_VERTEX_COUNT = 3'd3;
    localparam logic [2:0] REG_STEP         = 3'd4;
    localparam logic [2:0] REG_AMPLITUDE    = 3'd5;
    localparam logic [2:0] REG_PULSE_LENGTH = 3'd6;
    localparam logic [2:0] REG_SAMPLE_OFS   = 3'd7;

    localparam logic signed [CALC_W-1:0] LVL_MAX = 20'sd65535;
    localparam logic signed [CALC_W-1:0] LVL_MIN = -20'sd65536;

    typedef enum logic [1:0] {
        KIND_DONE   = 2'd0,
        KIND_SET    = 2'd1,
        KIND_SAMPLE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_INI    = 3'd0,
        PH_HIGH_V = 3'd1,
        PH_HIGH_S = 3'd2,
        PH_LOW_V  = 3'd3,
        PH_LOW_S  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_SPAN     = 3'd1,
        ST_DIV_LOAD = 3'd2,
        ST_DIV      = 3'd3,
        ST_MUL      = 3'd4,
        ST_FIN      = 3'd5,
        ST_STEP     = 3'd6
    } ctrl_state_t;

    typedef struct packed {
        logic sweep_init;
        logic span_step;
        logic div_load;
        logic div_step;
        logic mul;
        logic fin;
        logic step;
    } swvs_cmd_t;

    typedef struct packed {
        logic span_last;
        logic div_last;
        logic out_free;
    } swvs_status_t;

    function automatic logic signed [LVL_W-1:0] sat_level(input logic signed [CALC_W-1:0] v);
        logic signed [CALC_W-1:0] r;
        r = v;
        if (v > LVL_MAX) begin
            r = LVL_MAX;
        end else if (v < LVL_MIN) begin
            r = LVL_MIN;
        end
        return r[LVL_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    // vertex potential minus amplitude
    function automatic logic signed [LVL_W-1:0] vertex_level(input logic [63:0] tbl,
                                                             input logic [1:0]  k,
                                                             input logic [14:0] amp);
        logic [15:0] raw;
        raw = tbl[{k, 4'b0000} +: 16];
        return $signed({raw[15], raw}) - $signed({2'b00, amp});
    endfunction

    function automatic logic signed [CALC_W-1:0] ext_level(input logic signed [LVL_W-1:0] v);
        return {{(CALC_W-LVL_W){v[LVL_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

>>> rtl/swvs_ctrl.sv
// controller state machine: handshake on the request side and sequencing of the datapath
`default_nettype none

module swvs_ctrl
    import swvs_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire logic   s_restart,
    input  wire swvs_status_t status,
    output swvs_cmd_t   cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_restart ? ST_SPAN : ST_STEP;
                end
            end
            ST_SPAN: begin
                if (status.span_last) begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            ST_STEP: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        cmd            = '0;
        cmd.sweep_init = (state_reg == ST_IDLE) && s_valid && s_restart;
        cmd.span_step  = (state_reg == ST_SPAN);
        cmd.div_load   = (state_reg == ST_DIV_LOAD);
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.mul        = (state_reg == ST_MUL);
        cmd.fin        = (state_reg == ST_FIN);
        cmd.step       = (state_reg == ST_STEP) && status.out_free;
    end

endmodule

`default_nettype wire

>>> rtl/swvs_datapath.sv
// datapath: settings, sweep state, span sum, serial divider, multiplier and result register
`default_nettype none

module swvs_datapath
    import swvs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [63:0]           cfg_data,
    input  wire swvs_cmd_t             cmd,
    output swvs_status_t               status,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_action_kind,
    output logic [TIME_W-1:0]          m_action_time_us,
    output logic signed [LVL_W-1:0]    m_level_mv
);

    // settings
    logic signed [15:0] start_reg;
    logic signed [15:0] end_reg;
    logic [63:0]        vtab_reg;
    logic [2:0]         vcount_reg;
    logic [14:0]        step_reg;
    logic [14:0]        amp_reg;
    logic [19:0]        pulse_reg;
    logic [18:0]        offset_reg;

    // sweep state
    phase_t                   phase_reg,   phase_next;
    logic [TIME_W-1:0]        elapsed_reg, elapsed_next;
    logic signed [LVL_W-1:0]  base_reg,    base_next;
    logic signed [LVL_W-1:0]  brk_reg,     brk_next;
    logic                     up_reg,      up_next;
    logic                     vdone_reg,   vdone_next;
    logic [2:0]               vidx_reg,    vidx_next;
    logic [TIME_W-1:0]        active_reg,  active_next;

    // restart arithmetic
    logic signed [LVL_W-1:0]  prev_reg,    prev_next;
    logic [2:0]               seg_reg,     seg_next;
    logic [TOTAL_W-1:0]       total_reg,   total_next;
    logic [REM_W-1:0]         rem_reg,     rem_next;
    logic [TOTAL_W-1:0]       quot_reg,    quot_next;
    logic [DIV_CNT_W-1:0]     cnt_reg,     cnt_next;
    logic [PROD_W-1:0]        prod_reg,    prod_next;

    // result register
    logic                     m_valid_reg, m_valid_next;
    kind_t                    kind_reg,    kind_next;
    logic [TIME_W-1:0]        time_reg,    time_next;
    logic signed [LVL_W-1:0]  level_reg,   level_next;

    logic [2:0]               used_n;
    logic signed [LVL_W-1:0]  start_lvl;
    logic signed [LVL_W-1:0]  end_lvl;
    logic signed [LVL_W-1:0]  init_brk;
    logic                     init_up;
    logic signed [CALC_W-1:0] step_ext;
    logic signed [CALC_W-1:0] amp_ext;
    logic signed [LVL_W-1:0]  span_tgt;
    logic signed [LVL_W:0]    span_diff;
    logic [LVL_W:0]           span_abs;
    logic [14:0]              divisor;
    logic [REM_W:0]           shifted;
    logic                     div_ge;
    logic [REM_W:0]           shifted_sub;
    logic [18:0]              half_pulse;
    logic [TIME_W-1:0]        gap_us;
    logic [TIME_W-1:0]        ofs_ext;
    logic [TIME_W-1:0]        el_ofs;
    logic [TIME_W-1:0]        el_gap;
    logic signed [LVL_W-1:0]  base_moved;
    logic                     brk_hit;
    logic [2:0]               vidx_inc;
    logic signed [LVL_W-1:0]  base_turn;

    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.span_last = (seg_reg == used_n);
    assign status.div_last  = (cnt_reg == DIV_CNT_W'(TOTAL_W - 1));

    assign m_valid          = m_valid_reg;
    assign m_action_kind    = kind_reg;
    assign m_action_time_us = time_reg;
    assign m_level_mv       = level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            end_reg    <= '0;
            vtab_reg   <= '0;
            vcount_reg <= '0;
            step_reg   <= 15'd1;
            amp_reg    <= '0;
            pulse_reg  <= 20'd1000;
            offset_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_LEVEL:  start_reg  <= cfg_data[15:0];
                REG_END_LEVEL:    end_reg    <= cfg_data[15:0];
                REG_VERTEX_TABLE: vtab_reg   <= cfg_data;
                REG_VERTEX_COUNT: vcount_reg <= cfg_data[2:0];
                REG_STEP:         step_reg   <= cfg_data[14:0];
                REG_AMPLITUDE:    amp_reg    <= cfg_data[14:0];
                REG_PULSE_LENGTH: pulse_reg  <= cfg_data[19:0];
                REG_SAMPLE_OFS:   offset_reg <= cfg_data[18:0];
                default: ;
            endcase
        end
    end

    // derived settings
    always_comb begin
        used_n    = (vcount_reg > MAX_VERTICES) ? MAX_VERTICES : vcount_reg;
        start_lvl = $signed({start_reg[15], start_reg}) - $signed({2'b00, amp_reg});
        end_lvl   = $signed({end_reg[15], end_reg}) - $signed({2'b00, amp_reg});
        init_brk  = (used_n == 3'd0) ? end_lvl : vertex_level(vtab_reg, 2'd0, amp_reg);
        init_up   = (start_lvl < init_brk);
        step_ext  = $signed({5'b00000, step_reg});
        amp_ext   = $signed({5'b00000, amp_reg});

        span_tgt  = (seg_reg < used_n) ? vertex_level(vtab_reg, seg_reg[1:0], amp_reg)
                                       : end_lvl;
        span_diff = $signed({span_tgt[LVL_W-1], span_tgt})
                  - $signed({prev_reg[LVL_W-1], prev_reg});
        span_abs  = span_diff[LVL_W] ? (LVL_W+1)'(1) + (LVL_W+1)'(~span_diff) : span_diff;

        divisor     = (step_reg == 15'd0) ? 15'd1 : step_reg;
        shifted     = {rem_reg, quot_reg[TOTAL_W-1]};
        div_ge      = (shifted >= {1'b0, divisor});
        shifted_sub = shifted - {1'b0, divisor};

        half_pulse = pulse_reg[19:1];
        gap_us     = (half_pulse >= offset_reg) ? TIME_W'(half_pulse - offset_reg) : '0;
        ofs_ext    = TIME_W'(offset_reg);
        el_ofs     = sat_add(elapsed_reg, ofs_ext);
        el_gap     = sat_add(elapsed_reg, gap_us);

        base_moved = sat_level(up_reg ? ext_level(base_reg) + step_ext
                                      : ext_level(base_reg) - step_ext);
        brk_hit    = !vdone_reg && ((up_reg && (base_moved >= brk_reg)) ||
                                    (!up_reg && (base_moved <= brk_reg)));
        vidx_inc   = vidx_reg + 3'd1;
        base_turn  = brk_hit ? brk_reg : base_moved;
    end

    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        base_next    = base_reg;
        brk_next     = brk_reg;
        up_next      = up_reg;
        vdone_next   = vdone_reg;
        vidx_next    = vidx_reg;
        active_next  = active_reg;
        prev_next    = prev_reg;
        seg_next     = seg_reg;
        total_next   = total_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        time_next    = time_reg;
        level_next   = level_reg;

        if (cmd.sweep_init) begin
            elapsed_next = '0;
            vidx_next    = '0;
            vdone_next   = (used_n == 3'd0);
            brk_next     = init_brk;
            up_next      = init_up;
            base_next    = sat_level(init_up ? ext_level(start_lvl) + step_ext
                                             : ext_level(start_lvl) - step_ext);
            phase_next   = PH_INI;
            prev_next    = start_lvl;
            seg_next     = '0;
            total_next   = '0;
        end

        if (cmd.span_step) begin
            total_next = total_reg + TOTAL_W'(span_abs);
            prev_next  = span_tgt;
            seg_next   = seg_reg + 3'd1;
        end

        if (cmd.div_load) begin
            rem_next  = '0;
            quot_next = total_reg;
            cnt_next  = '0;
        end

        if (cmd.div_step) begin
            rem_next  = div_ge ? shifted_sub[REM_W-1:0] : shifted[REM_W-1:0];
            quot_next = {quot_reg[TOTAL_W-2:0], div_ge};
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.mul) begin
            prod_next = quot_reg * pulse_reg;
        end

        if (cmd.fin) begin
            active_next = (prod_reg[PROD_W-1:TIME_W] != '0) ? {TIME_W{1'b1}}
                                                            : prod_reg[TIME_W-1:0];
        end

        if (cmd.step) begin
            m_valid_next = 1'b1;
            unique case (phase_reg)
                PH_INI: begin
                    phase_next = PH_HIGH_S;
                    kind_next  = KIND_SET;
                    time_next  = elapsed_reg;
                    level_next = sat_level(ext_level(base_reg) + amp_ext);
                end
                PH_HIGH_V: begin
                    elapsed_next = el_ofs;
                    if (el_ofs >= active_reg) begin
                        kind_next  = KIND_DONE;
                        time_next  = '0;
                        level_next = '0;
                    end else begin
                        base_next  = base_turn;
                        if (brk_hit) begin
                            up_next   = !up_reg;
                            vidx_next = vidx_inc;
                            if (vidx_inc >= used_n) begin
                                vdone_next = 1'b1;
                            end else begin
                                brk_next = vertex_level(vtab_reg, vidx_inc[1:0], amp_reg);
                            end
                        end
                        phase_next = PH_HIGH_S;
                        kind_next  = KIND_SET;
                        time_next  = el_ofs;
                        level_next = sat_level(ext_level(base_turn) + amp_ext);
                    end
                end
                PH_HIGH_S: begin
                    elapsed_next = el_gap;
                    phase_next   = PH_LOW_V;
                    kind_next    = KIND_SAMPLE;
                    time_next    = el_gap;
                    level_next   = '0;
                end
                PH_LOW_V: begin
                    elapsed_next = el_ofs;
                    phase_next   = PH_LOW_S;
                    kind_next    = KIND_SET;
                    time_next    = el_ofs;
                    level_next   = sat_level(ext_level(base_reg) - amp_ext);
                end
                PH_LOW_S: begin
                    elapsed_next = el_gap;
                    phase_next   = PH_HIGH_V;
                    kind_next    = KIND_SAMPLE;
                    time_next    = el_gap;
                    level_next   = '0;
                end
                default: begin
                    kind_next  = KIND_DONE;
                    time_next  = '0;
                    level_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_INI;
            elapsed_reg <= '0;
            base_reg    <= '0;
            brk_reg     <= '0;
            up_reg      <= 1'b0;
            vdone_reg   <= 1'b1;
            vidx_reg    <= '0;
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            base_reg    <= base_next;
            brk_reg     <= brk_next;
            up_reg      <= up_next;
            vdone_reg   <= vdone_next;
            vidx_reg    <= vidx_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg  <= prev_next;
        seg_reg   <= seg_next;
        total_reg <= total_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        cnt_reg   <= cnt_next;
        prod_reg  <= prod_next;
        kind_reg  <= kind_next;
        time_reg  <= time_next;
        level_reg <= level_next;
    end

endmodule

`default_nettype wire

>>> rtl/square_wave_voltammetry_sequencer_core.sv
// top level of the square-wave voltammetry waveform sequencer
//
//  channel   ports                                   direction  payload
//  request   s_valid s_ready s_restart               in         restart flag
//  action    m_valid m_ready m_action_kind           out        kind, time (us), level (mV)
//            m_action_time_us m_level_mv
//  settings  cfg_valid cfg_ready cfg_index cfg_data  in         register write, always ready
//
// a next-action request is accepted, then a compute state loads the output register;
// it waits there while a previous action is still not transferred
// a restart sums the span segment by segment (vertex count, capped at four, plus one
// segments), then loads and runs the serial restoring divider, multiplies and saturates
// s_ready is high only while the controller is idle; reset is synchronous, active low,
// and leaves the sweep in its cleared state with all settings at their reset values
`default_nettype none

module square_wave_voltammetry_sequencer_core
    import swvs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_restart,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_action_kind,
    output logic [TIME_W-1:0]       m_action_time_us,
    output logic signed [LVL_W-1:0] m_level_mv,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data
);

    swvs_cmd_t    cmd;
    swvs_status_t status;

    assign cfg_ready = 1'b1;

    swvs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .status    (status),
        .cmd       (cmd)
    );

    swvs_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_action_kind    (m_action_kind),
        .m_action_time_us (m_action_time_us),
        .m_level_mv       (m_level_mv)
    );

endmodule

`default_nettype wire

>>> rtl/swvs_checker.sv
// port-level checker for the sequencer and its bind to the top level
`default_nettype none

module swvs_checker
    import swvs_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               s_restart,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [1:0]         m_action_kind,
    input wire logic [TIME_W-1:0]  m_action_time_us,
    input wire logic [LVL_W-1:0]   m_level_mv
);

    // a stalled action holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action_kind) &&
        $stable(m_action_time_us) && $stable(m_level_mv))
        else $error("action changed while stalled");

    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action_kind == KIND_DONE) |->
        (m_action_time_us == '0) && (m_level_mv == '0))
        else $error("done action with nonzero time or level");

    a_sample_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action_kind == KIND_SAMPLE) |-> (m_level_mv == '0))
        else $error("sample action with nonzero level");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_action_kind == KIND_DONE) || (m_action_kind == KIND_SET) ||
        (m_action_kind == KIND_SAMPLE))
        else $error("illegal action kind");

    // a restart never produces an action
    a_restart_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_restart |=> !$rose(m_valid))
        else $error("action raised after restart transfer");

endmodule

bind square_wave_voltammetry_sequencer_core swvs_checker u_swvs_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_restart        (s_restart),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_action_kind    (m_action_kind),
    .m_action_time_us (m_action_time_us),
    .m_level_mv       (m_level_mv)
);

`default_nettype wire

>>> bench/testbench.sv
// testbench for the square-wave voltammetry sequencer: directed and random sweeps checked against a predictor
`timescale 1ns / 100ps

module testbench;
    import swvs_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PRINT_LIMIT  = 50;

    localparam int RX_OPEN     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_SPARSE   = 3;

    typedef struct {
        kind_t                   kind;
        logic [TIME_W-1:0]       at_us;
        logic signed [LVL_W-1:0] level;
    } action_t;

    logic                    aclk;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_restart = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_action_kind;
    logic [TIME_W-1:0]       m_action_time_us;
    logic signed [LVL_W-1:0] m_level_mv;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [2:0]              cfg_index = REG_START_LEVEL;
    logic [63:0]             cfg_data = '0;

    // register mirror
    logic signed [15:0] r_start = '0;
    logic signed [15:0] r_end = '0;
    logic [63:0]        r_vtable = '0;
    logic [2:0]         r_vcount = '0;
    logic [14:0]        r_step = 15'd1;
    logic [14:0]        r_amp = '0;
    logic [19:0]        r_pulse = 20'd1000;
    logic [18:0]        r_ofs = '0;

    // sweep state
    phase_t                  sw_phase = PH_INI;
    logic [TIME_W-1:0]       sw_elapsed = '0;
    logic [TIME_W-1:0]       sw_active = '0;
    logic signed [LVL_W-1:0] sw_base = '0;
    logic signed [LVL_W-1:0] sw_brk = '0;
    bit                      sw_up = 1'b0;
    bit                      sw_vdone = 1'b1;
    logic [2:0]              sw_vidx = '0;

    action_t     pending_actions[$];
    logic [63:0] reg_value[8];
    bit          reg_sel[8];

    int          fail_count = 0;
    int          items_sent = 0;
    int          request_count = 0;
    int          restart_count = 0;
    int          setups = 0;
    int          actions_seen = 0;
    int          sets_seen = 0;
    int          samples_seen = 0;
    int          dones_seen = 0;
    int          saturated_seen = 0;
    int          burst_left = 0;
    int unsigned rx_cycle = 0;
    int          rx_mode = RX_OPEN;

    square_wave_voltammetry_sequencer_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_action_kind    (m_action_kind),
        .m_action_time_us (m_action_time_us),
        .m_level_mv       (m_level_mv),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic signed [LVL_W-1:0] clamp_level(input int v);
        if (v > 65535) begin
            v = 65535;
        end else if (v < -65536) begin
            v = -65536;
        end
        return v[LVL_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        return (s > 64'hFFFF_FFFF) ? '1 : 32'(s);
    endfunction

    function automatic int mv_span(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int used_vertices(input logic [2:0] cnt);
        return (cnt > MAX_VERTICES) ? int'(MAX_VERTICES) : int'(cnt);
    endfunction

    function automatic int vertex_mv(input int k);
        return int'($signed(r_vtable[16*(k & 3) +: 16])) - int'(r_amp);
    endfunction

    function automatic int span_total(input logic signed [15:0] st16,
                                      input logic signed [15:0] en16,
                                      input logic [63:0] tbl, input logic [2:0] cnt,
                                      input logic [14:0] amp);
        int a, st, en, n, tot, prev, cur;
        a = amp;
        st = int'(st16) - a;
        en = int'(en16) - a;
        n = used_vertices(cnt);
        tot = 0;
        prev = st;
        for (int i = 0; i < n; i++) begin
            cur = int'($signed(tbl[16*i +: 16])) - a;
            tot += mv_span(cur, prev);
            prev = cur;
        end
        return tot + mv_span(en, prev);
    endfunction

    function automatic void sweep_restart();
        int st, en, n, tot, stp;
        longint prod;
        st = int'(r_start) - int'(r_amp);
        en = int'(r_end) - int'(r_amp);
        n = used_vertices(r_vcount);
        sw_elapsed = '0;
        sw_vidx = '0;
        if (n == 0) begin
            sw_vdone = 1'b1;
            sw_brk = clamp_level(en);
        end else begin
            sw_vdone = 1'b0;
            sw_brk = clamp_level(vertex_mv(0));
        end
        tot = span_total(r_start, r_end, r_vtable, r_vcount, r_amp);
        sw_up = st < int'(sw_brk);
        sw_base = clamp_level(sw_up ? st + int'(r_step) : st - int'(r_step));
        stp = (r_step == 0) ? 1 : int'(r_step);
        prod = longint'(tot / stp) * longint'(r_pulse);
        sw_active = (prod > 64'hFFFF_FFFF) ? '1 : 32'(prod);
        sw_phase = PH_INI;
    endfunction

    function automatic logic [TIME_W-1:0] sample_gap();
        int center;
        center = r_pulse / 2;
        return (center >= int'(r_ofs)) ? 32'(center - int'(r_ofs)) : '0;
    endfunction

    function automatic action_t make_action(input kind_t k, input logic [TIME_W-1:0] t,
                                            input int lvl);
        action_t a;
        a.kind = k;
        a.at_us = t;
        a.level = clamp_level(lvl);
        return a;
    endfunction

    function automatic action_t next_action();
        int amp, stp;
        action_t a;
        amp = r_amp;
        stp = r_step;
        case (sw_phase)
            PH_INI: begin
                sw_phase = PH_HIGH_S;
                a = make_action(KIND_SET, sw_elapsed, int'(sw_base) + amp);
            end
            PH_HIGH_V: begin
                sw_elapsed = time_add(sw_elapsed, r_ofs);
                if (sw_elapsed >= sw_active) begin
                    a = make_action(KIND_DONE, '0, 0);
                end else begin
                    sw_base = clamp_level(sw_up ? int'(sw_base) + stp : int'(sw_base) - stp);
                    if (!sw_vdone && ((sw_up && sw_base >= sw_brk) ||
                                      (!sw_up && sw_base <= sw_brk))) begin
                        sw_up = !sw_up;
                        sw_base = sw_brk;
                        sw_vidx = sw_vidx + 3'd1;
                        if (sw_vidx >= used_vertices(r_vcount)) begin
                            sw_vdone = 1'b1;
                        end else begin
                            sw_brk = clamp_level(vertex_mv(sw_vidx));
                        end
                    end
                    sw_phase = PH_HIGH_S;
                    a = make_action(KIND_SET, sw_elapsed, int'(sw_base) + amp);
                end
            end
            PH_HIGH_S: begin
                sw_elapsed = time_add(sw_elapsed, sample_gap());
                sw_phase = PH_LOW_V;
                a = make_action(KIND_SAMPLE, sw_elapsed, 0);
            end
            PH_LOW_V: begin
                sw_elapsed = time_add(sw_elapsed, r_ofs);
                sw_phase = PH_LOW_S;
                a = make_action(KIND_SET, sw_elapsed, int'(sw_base) - amp);
            end
            PH_LOW_S: begin
                sw_elapsed = time_add(sw_elapsed, sample_gap());
                sw_phase = PH_HIGH_V;
                a = make_action(KIND_SAMPLE, sw_elapsed, 0);
            end
            default: begin
                a = make_action(KIND_DONE, '0, 0);
            end
        endcase
        return a;
    endfunction

    function automatic void store_reg(input logic [2:0] idx, input logic [63:0] data);
        case (idx)
            REG_START_LEVEL:  r_start = data[15:0];
            REG_END_LEVEL:    r_end = data[15:0];
            REG_VERTEX_TABLE: r_vtable = data;
            REG_VERTEX_COUNT: r_vcount = data[2:0];
            REG_STEP:         r_step = data[14:0];
            REG_AMPLITUDE:    r_amp = data[14:0];
            REG_PULSE_LENGTH: r_pulse = data[19:0];
            default:          r_ofs = data[18:0];
        endcase
    endfunction

    // unused upper bits of the write data carry random noise
    function automatic void set_reg(input logic [2:0] idx, input logic [63:0] v);
        int w;
        logic [63:0] mask, noise;
        case (idx)
            REG_START_LEVEL, REG_END_LEVEL: w = 16;
            REG_VERTEX_TABLE:               w = 64;
            REG_VERTEX_COUNT:               w = 3;
            REG_STEP, REG_AMPLITUDE:        w = 15;
            REG_PULSE_LENGTH:               w = 20;
            default:                        w = 19;
        endcase
        mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        noise = {$urandom, $urandom};
        reg_value[idx] = (noise & ~mask) | (v & mask);
        reg_sel[idx] = 1'b1;
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_action();
        action_t e;
        actions_seen++;
        if (pending_actions.size() == 0) begin
            report_mismatch($sformatf("action transfer %0d with nothing expected", actions_seen));
        end else begin
            e = pending_actions.pop_front();
            if (m_action_kind !== e.kind) begin
                report_mismatch($sformatf("action %0d kind got %0d expected %0d",
                                          actions_seen, m_action_kind, e.kind));
            end
            if (m_action_time_us !== e.at_us) begin
                report_mismatch($sformatf("action %0d time got %0d expected %0d",
                                          actions_seen, m_action_time_us, e.at_us));
            end
            if (m_level_mv !== e.level) begin
                report_mismatch($sformatf("action %0d level got %0d expected %0d",
                                          actions_seen, m_level_mv, e.level));
            end
            case (e.kind)
                KIND_SET:    sets_seen++;
                KIND_SAMPLE: samples_seen++;
                default:     dones_seen++;
            endcase
            if (e.at_us == '1) begin
                saturated_seen++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_action();
        end
        if (rx_cycle % 97 == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_SPARSE);
        end
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:     m_ready <= 1'b1;
            RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_ready <= (rx_cycle % 5 == 0);
            default:     m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_item(input bit restart, output bit got_done);
        int gap;
        action_t a;
        got_done = 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                s_restart <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (restart) begin
            sweep_restart();
            restart_count++;
        end else begin
            a = next_action();
            pending_actions.push_back(a);
            request_count++;
            got_done = (a.kind == KIND_DONE);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_regs();
        for (int i = 0; i < 8; i++) begin
            if (reg_sel[i]) begin
                cfg_valid <= 1'b1;
                cfg_index <= 3'(i);
                cfg_data <= reg_value[i];
                do @(posedge aclk); while (!cfg_ready);
                store_reg(3'(i), reg_value[i]);
                reg_sel[i] = 1'b0;
            end
        end
        cfg_valid <= 1'b0;
        setups++;
    endtask

    task automatic sweep_until_done(input int cap, input int dones_wanted);
        int dones;
        bit d;
        dones = 0;
        for (int i = 0; i < cap && dones < dones_wanted; i++) begin
            send_item(1'b0, d);
            dones += d;
        end
    endtask

    task automatic test_cleared_state();
        sweep_until_done(6, 2);
        settle();
    endtask

    task automatic test_level_limits();
        bit d;
        set_reg(REG_START_LEVEL, 64'h7FFF);
        set_reg(REG_END_LEVEL, 64'h8000);
        set_reg(REG_VERTEX_TABLE, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        set_reg(REG_VERTEX_COUNT, 64'd7);
        set_reg(REG_STEP, 64'h7FFF);
        set_reg(REG_AMPLITUDE, 64'h7FFF);
        set_reg(REG_PULSE_LENGTH, 64'hFFFFF);
        set_reg(REG_SAMPLE_OFS, 64'h7FFFF);
        apply_regs();
        send_item(1'b1, d);
        sweep_until_done(14, 1);
        settle();
    endtask

    // zero step and a sample offset past half the pulse
    task automatic test_zero_step();
        bit d;
        set_reg(REG_START_LEVEL, 64'd0);
        set_reg(REG_END_LEVEL, 64'd3);
        set_reg(REG_VERTEX_TABLE, 64'd0);
        set_reg(REG_VERTEX_COUNT, 64'd0);
        set_reg(REG_STEP, 64'd0);
        set_reg(REG_AMPLITUDE, 64'd5);
        set_reg(REG_PULSE_LENGTH, 64'd3);
        set_reg(REG_SAMPLE_OFS, 64'd2);
        apply_regs();
        send_item(1'b1, d);
        sweep_until_done(20, 2);
        settle();
    endtask

    // active time saturates, a few of the longest pulses run against it
    task automatic test_time_saturation();
        bit d;
        set_reg(REG_START_LEVEL, 64'h8000);
        set_reg(REG_END_LEVEL, 64'h7FFF);
        set_reg(REG_VERTEX_TABLE, 64'd0);
        set_reg(REG_VERTEX_COUNT, 64'd0);
        set_reg(REG_STEP, 64'd1);
        set_reg(REG_AMPLITUDE, 64'd0);
        set_reg(REG_PULSE_LENGTH, 64'hFFFFF);
        set_reg(REG_SAMPLE_OFS, 64'h7FFFF);
        apply_regs();
        send_item(1'b1, d);
        sweep_until_done(40, 1);
        settle();
    endtask

    task automatic randomize_settings();
        logic [15:0] st, en;
        logic [63:0] tbl;
        logic [2:0]  cnt;
        logic [14:0] amp, stp;
        logic [19:0] pl;
        logic [18:0] ofs;
        int          tot, half, q;
        st = pick_level();
        en = pick_level();
        tbl = {pick_level(), pick_level(), pick_level(), pick_level()};
        cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        case ($urandom_range(0, 3))
            0:       amp = '0;
            1:       amp = '1;
            2:       amp = 15'($urandom_range(0, 300));
            default: amp = 15'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       pl = 20'($urandom_range(0, 1));
            1:       pl = '1;
            2:       pl = 20'd2;
            default: pl = 20'($urandom_range(2, 5000));
        endcase
        half = pl / 2;
        case ($urandom_range(0, 5))
            0:       ofs = '0;
            1:       ofs = 19'(half);
            2:       ofs = 19'(half + $urandom_range(1, 100));
            3:       ofs = '1;
            default: ofs = 19'($urandom_range(0, half));
        endcase
        tot = span_total(st, en, tbl, cnt, amp);
        case ($urandom_range(0, 7))
            0:       stp = '0;
            1:       stp = '1;
            2:       stp = 15'($urandom);
            default: begin
                q = tot / $urandom_range(1, 30);
                stp = (q == 0) ? 15'd1 : ((q > 32767) ? 15'h7FFF : 15'(q));
            end
        endcase
        set_reg(REG_START_LEVEL, st);
        set_reg(REG_END_LEVEL, en);
        set_reg(REG_VERTEX_TABLE, tbl);
        set_reg(REG_VERTEX_COUNT, cnt);
        set_reg(REG_STEP, stp);
        set_reg(REG_AMPLITUDE, amp);
        set_reg(REG_PULSE_LENGTH, pl);
        set_reg(REG_SAMPLE_OFS, ofs);
    endtask

    // mostly restart then run to done, with stray restarts mid sweep
    task automatic test_random_sweeps();
        int first, cap, dones_wanted, dones;
        bit d;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                randomize_settings();
                apply_regs();
            end
            if ($urandom_range(0, 9) != 0) begin
                send_item(1'b1, d);
            end
            cap = $urandom_range(8, 120);
            dones_wanted = $urandom_range(1, 3);
            dones = 0;
            for (int i = 0; i < cap && dones < dones_wanted; i++) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_item(1'b1, d);
                end else begin
                    send_item(1'b0, d);
                    dones += d;
                end
            end
            settle();
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_cleared_state();
        test_level_limits();
        test_zero_step();
        test_time_saturation();
        test_random_sweeps();
        settle();
        $display("covered %0d requests and %0d restarts over %0d register setups",
                 request_count, restart_count, setups);
        $display("checked %0d action transfers: %0d level sets, %0d samples, %0d done, %0d at max time",
                 actions_seen, sets_seen, samples_seen, dones_seen, saturated_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/swvs_pkg.sv
rtl/swvs_ctrl.sv
rtl/swvs_datapath.sv
rtl/square_wave_voltammetry_sequencer_core.sv
rtl/swvs_checker.sv
bench/testbench.sv
